@@ sv/rhhs_pkg.sv @@
// Package: request, status and state codes for the Robin Hood hash set.
`timescale 1ns / 1ps
package rhhs_pkg;
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SCAN,
        S_SHIFT,
        S_ERASE,
        S_RESULT
    } fsm_t;
endpackage

@@ sv/rhhs_if.sv @@
// Interfaces: valid/ready channels for requests and results.
`timescale 1ns / 1ps
interface rhhs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [9:0]  home_slot;
    modport source (output valid, req_type, key, home_slot, input ready);
    modport sink (input valid, req_type, key, home_slot, output ready);
endinterface

interface rhhs_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [1:0]  status;
    logic [9:0]  found_slot;
    logic [10:0] entry_total;
    modport source (output valid, ok, status, found_slot, entry_total, input ready);
    modport sink (input valid, ok, status, found_slot, entry_total, output ready);
endinterface

@@ sv/rhhs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rhhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/robin_hood_hash_set_unit.sv @@
// Top level: Robin Hood hash set with backward-shift deletion.
`timescale 1ns / 1ps
// One request is taken at a time: it is accepted, then the probe visits one slot at a
// time, each visit a memory read followed by the decision. An insert of an absent key
// probes again from the home slot up to the slot where it places the key, then shifts
// forward each entry it displaces. A remove reads each slot it examines during the
// back-shift, the slot that ends it included. The result is then held until it is
// taken. The slot memories have a single read port. After reset a clearing pass marks
// every slot empty before the first request is accepted.
module robin_hood_hash_set_unit #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic clk,
    input  logic rst_n,
    rhhs_req_if.sink   req,
    rhhs_rsp_if.source rsp
);
    import rhhs_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int EW = 1 + KEY_BITS;
    localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

    fsm_t state_reg, state_next;
    logic          clr_reg, clr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] home_reg, home_next;
    logic [CW-1:0] probe_reg, probe_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    rq_reg, rq_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [EW-1:0] carry_reg, carry_next;
    logic          pend_reg, pend_next;
    logic          ok_reg, ok_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] fs_reg, fs_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [AW-1:0] dist_w;
    logic          used_r;
    logic [AW-1:0] dist_r;
    logic [KEY_BITS-1:0] key_r;
    logic [AW-1:0] home;

    rhhs_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );
    rhhs_ram #(.WIDTH(AW), .DEPTH(TABLE_SLOTS)) u_dist (
        .clk(clk), .we(we), .waddr(waddr), .wdata(dist_w), .raddr(raddr), .rdata(dist_r)
    );

    assign used_r = rdata[EW-1];
    assign key_r  = rdata[KEY_BITS-1:0];
    assign home   = AW'({22'd0, req.home_slot} % TABLE_SLOTS);

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        nxt = (i == LAST) ? '0 : i + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clr_reg   <= 1'b1;
            idx_reg   <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        home_reg  <= home_next;
        probe_reg <= probe_next;
        rq_reg    <= rq_next;
        key_reg   <= key_next;
        carry_reg <= carry_next;
        ok_reg    <= ok_next;
        st_reg    <= st_next;
        fs_reg    <= fs_next;
    end

    // pend_reg: a read of idx_reg was issued last cycle, rdata is valid now.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        home_next  = home_reg;
        probe_next = probe_reg;
        count_next = count_reg;
        rq_next    = rq_reg;
        key_next   = key_reg;
        carry_next = carry_reg;
        pend_next  = 1'b0;
        ok_next    = ok_reg;
        st_next    = st_reg;
        fs_next    = fs_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = '0;
        dist_w     = '0;
        raddr      = idx_reg;
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (clr_reg)
                begin
                    we = 1'b1;
                    idx_next = nxt(idx_reg);
                    if (idx_reg == LAST)
                    begin
                        clr_next = 1'b0;
                    end
                end
                else
                begin
                    req.ready = 1'b1;
                    if (req.valid)
                    begin
                        rq_next    = req.req_type;
                        key_next   = req.key[KEY_BITS-1:0];
                        idx_next   = home;
                        home_next  = home;
                        probe_next = '0;
                        ok_next    = 1'b0;
                        st_next    = ST_ABSENT;
                        fs_next    = '0;
                        if (req.req_type == REQ_NONE)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (probe_reg >= count_reg || !used_r
                         || (used_r && key_r != key_reg && CW'(probe_reg) > CW'(dist_r)))
                begin
                    // key absent
                    if (rq_reg == REQ_INSERT)
                    begin
                        if (count_reg >= CW'(TABLE_SLOTS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            // insert restarts its scan from the home slot
                            idx_next = home_reg;
                            probe_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (key_r == key_reg)
                begin
                    fs_next = idx_reg;
                    if (rq_reg == REQ_INSERT)
                    begin
                        st_next = ST_DUP;
                        state_next = S_RESULT;
                    end
                    else if (rq_reg == REQ_REMOVE)
                    begin
                        ok_next = 1'b1;
                        st_next = ST_DONE;
                        count_next = count_reg - 1'b1;
                        pos_next = idx_reg;
                        idx_next = nxt(idx_reg);
                        state_next = S_ERASE;
                    end
                    else
                    begin
                        ok_next = 1'b1;
                        st_next = ST_DONE;
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    idx_next = nxt(idx_reg);
                    probe_next = probe_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                // find placement slot, then carry entries forward until empty
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (!used_r || CW'(probe_reg) > CW'(dist_r))
                begin
                    we = 1'b1;
                    wdata = {1'b1, key_reg};
                    dist_w = AW'(probe_reg);
                    ok_next = 1'b1;
                    st_next = ST_DONE;
                    fs_next = idx_reg;
                    count_next = count_reg + 1'b1;
                    if (!used_r)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        carry_next = rdata;
                        pos_next = dist_r + 1'b1;
                        idx_next = nxt(idx_reg);
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    idx_next = nxt(idx_reg);
                    probe_next = probe_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // pos_reg holds carried entry's new distance
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    wdata = carry_reg;
                    dist_w = pos_reg;
                    if (!used_r)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        carry_next = rdata;
                        pos_next = dist_r + 1'b1;
                        idx_next = nxt(idx_reg);
                    end
                end
            end
            S_ERASE:
            begin
                // pos_reg is the hole, idx_reg its successor
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    waddr = pos_reg;
                    if (!used_r || dist_r == '0)
                    begin
                        wdata = '0;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        wdata = rdata;
                        dist_w = dist_r - 1'b1;
                        pos_next = idx_reg;
                        idx_next = nxt(idx_reg);
                    end
                end
            end
            S_RESULT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.ok          = ok_reg;
    assign rsp.status      = st_reg;
    assign rsp.found_slot  = 10'(fs_reg);
    assign rsp.entry_total = 11'(count_reg);
endmodule

@@ sv/rhhs_checker.sv @@
// Checker: port-level assertions for the hash set, bound to the top level.
`timescale 1ns / 1ps
module rhhs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        ok,
    input logic [1:0]  status,
    input logic [9:0]  found_slot,
    input logic [10:0] entry_total
);
    import rhhs_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid)) else $error("request taken while result pending");
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (ok == (status == ST_DONE))) else $error("ok and status disagree");
    a_absent_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_ABSENT || status == ST_FULL)) |-> found_slot == 10'd0)
        else $error("found_slot nonzero on failure");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(entry_total))
        else $error("result dropped");
endmodule

bind robin_hood_hash_set_unit rhhs_checker u_rhhs_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .ok(rsp.ok), .status(rsp.status),
    .found_slot(rsp.found_slot), .entry_total(rsp.entry_total)
);
